FILE: sv/mtt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_pkg
// types and constants shared by the markup tag tokenizer modules
// ----------------------------------------------------------------------------
package mtt_pkg;

    // parser phase
    typedef enum logic [1:0] {
        PH_TEXT  = 2'd0,
        PH_TYPE  = 2'd1,
        PH_BODY  = 2'd2,
        PH_ERROR = 2'd3
    } phase_t;

    // event kinds carried on the result channel
    typedef enum logic [3:0] {
        EV_TEXT   = 4'd0,
        EV_OPEN   = 4'd1,
        EV_TYPE   = 4'd2,
        EV_LBRACE = 4'd3,
        EV_BODY   = 4'd4,
        EV_EQUALS = 4'd5,
        EV_SEMI   = 4'd6,
        EV_RBRACE = 4'd7,
        EV_QUOTED = 4'd8,
        EV_ERROR  = 4'd9,
        EV_END    = 4'd10
    } event_kind_t;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_TYPE_CHAR  = 3'd1,
        ERR_NO_TYPE    = 3'd2,
        ERR_TWO_EQUALS = 3'd3,
        ERR_BODY_CHAR  = 3'd4,
        ERR_INCOMPLETE = 3'd5
    } error_code_t;

    // special bytes
    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_HYPHEN     = 8'h2D;

    // byte class flags from the classifier to the parser
    typedef struct packed {
        logic is_percent;
        logic is_lbrace;
        logic is_rbrace;
        logic is_equals;
        logic is_semi;
        logic is_quote;
        logic is_letter;
        logic is_body;
    } byte_class_t;

endpackage : mtt_pkg
`default_nettype wire

FILE: sv/mtt_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_in_if
// byte channel into the tokenizer
// ----------------------------------------------------------------------------
interface mtt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface : mtt_in_if
`default_nettype wire

FILE: sv/mtt_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_out_if
// event channel out of the tokenizer
// ----------------------------------------------------------------------------
interface mtt_out_if #(
    parameter int OFFSET_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic [3:0]             event_kind;
    logic [OFFSET_BITS-1:0] event_offset;
    logic [2:0]             error_code;
    logic [OFFSET_BITS-1:0] tag_begin_offset;

    modport source (
        output valid, output event_kind, output event_offset,
        output error_code, output tag_begin_offset, input ready
    );
    modport sink (
        input valid, input event_kind, input event_offset,
        input error_code, input tag_begin_offset, output ready
    );
endinterface : mtt_out_if
`default_nettype wire

FILE: sv/mtt_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_classify
// sorts one document byte into the classes the parser acts on
// ----------------------------------------------------------------------------
module mtt_classify (
    input  wire logic [7:0]          text_byte,
    output mtt_pkg::byte_class_t     byte_class
);
    import mtt_pkg::*;

    logic is_upper;
    logic is_lower;
    logic is_digit;

    always_comb
    begin
        is_upper = (text_byte >= 8'h41) && (text_byte <= 8'h5A);
        is_lower = (text_byte >= 8'h61) && (text_byte <= 8'h7A);
        is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);

        byte_class.is_percent = (text_byte == CH_PERCENT);
        byte_class.is_lbrace  = (text_byte == CH_LBRACE);
        byte_class.is_rbrace  = (text_byte == CH_RBRACE);
        byte_class.is_equals  = (text_byte == CH_EQUALS);
        byte_class.is_semi    = (text_byte == CH_SEMI);
        byte_class.is_quote   = (text_byte == CH_QUOTE);
        byte_class.is_letter  = is_upper || is_lower;
        byte_class.is_body    = is_upper || is_lower || is_digit
                                || (text_byte == CH_UNDERSCORE)
                                || (text_byte == CH_HYPHEN);
    end

endmodule : mtt_classify
`default_nettype wire

FILE: sv/mtt_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_parser
// tag state machine: one beat in, one event out, state updated on accept
// ----------------------------------------------------------------------------
module mtt_parser #(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic                   end_of_text,
    input  mtt_pkg::byte_class_t        byte_class,
    output mtt_pkg::event_kind_t        event_kind,
    output logic [OFFSET_BITS-1:0]      event_offset,
    output mtt_pkg::error_code_t        error_code,
    output logic [OFFSET_BITS-1:0]      tag_begin_offset
);
    import mtt_pkg::*;

    phase_t                 phase_reg,         phase_next;
    logic                   quoted_reg,        quoted_next;
    logic                   equals_seen_reg,   equals_seen_next;
    logic                   type_empty_reg,    type_empty_next;
    logic [OFFSET_BITS-1:0] tag_start_reg,     tag_start_next;
    logic [OFFSET_BITS-1:0] position_reg,      position_next;
    error_code_t            err_code_reg,      err_code_next;
    logic [OFFSET_BITS-1:0] err_offset_reg,    err_offset_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TEXT;
            quoted_reg      <= 1'b0;
            equals_seen_reg <= 1'b0;
            type_empty_reg  <= 1'b1;
            tag_start_reg   <= '0;
            position_reg    <= '0;
            err_code_reg    <= ERR_NONE;
            err_offset_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            quoted_reg      <= quoted_next;
            equals_seen_reg <= equals_seen_next;
            type_empty_reg  <= type_empty_next;
            tag_start_reg   <= tag_start_next;
            position_reg    <= position_next;
            err_code_reg    <= err_code_next;
            err_offset_reg  <= err_offset_next;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        quoted_next      = quoted_reg;
        equals_seen_next = equals_seen_reg;
        type_empty_next  = type_empty_reg;
        tag_start_next   = tag_start_reg;
        err_code_next    = err_code_reg;
        err_offset_next  = err_offset_reg;
        position_next    = (position_reg == '1) ? position_reg
                                                : position_reg + OFFSET_BITS'(1);

        event_kind       = EV_TEXT;
        event_offset     = position_reg;
        error_code       = ERR_NONE;
        tag_begin_offset = tag_start_reg;

        if (end_of_text)
        begin
            // outcome of the document, then back to reset state
            unique case (phase_reg)
                PH_ERROR:
                begin
                    event_kind   = EV_ERROR;
                    error_code   = err_code_reg;
                    event_offset = err_offset_reg;
                end
                PH_TYPE, PH_BODY:
                begin
                    event_kind   = EV_ERROR;
                    error_code   = ERR_INCOMPLETE;
                    event_offset = tag_start_reg;
                end
                default:
                begin
                    event_kind = EV_END;
                end
            endcase
            phase_next       = PH_TEXT;
            quoted_next      = 1'b0;
            equals_seen_next = 1'b0;
            type_empty_next  = 1'b1;
            tag_start_next   = '0;
            position_next    = '0;
            err_code_next    = ERR_NONE;
            err_offset_next  = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_TEXT:
                begin
                    if (byte_class.is_percent)
                    begin
                        event_kind       = EV_OPEN;
                        tag_start_next   = position_reg;
                        type_empty_next  = 1'b1;
                        quoted_next      = 1'b0;
                        equals_seen_next = 1'b0;
                        phase_next       = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    if (byte_class.is_lbrace)
                    begin
                        event_kind = EV_LBRACE;
                        phase_next = PH_BODY;
                    end
                    else if (byte_class.is_letter)
                    begin
                        event_kind      = EV_TYPE;
                        type_empty_next = 1'b0;
                    end
                    else
                    begin
                        event_kind      = EV_ERROR;
                        phase_next      = PH_ERROR;
                        err_code_next   = ERR_TYPE_CHAR;
                        err_offset_next = position_reg;
                    end
                end
                PH_BODY:
                begin
                    if (quoted_reg)
                    begin
                        event_kind = EV_QUOTED;
                        if (byte_class.is_quote)
                            quoted_next = 1'b0;
                    end
                    else if (byte_class.is_quote)
                    begin
                        event_kind  = EV_QUOTED;
                        quoted_next = 1'b1;
                    end
                    else if (byte_class.is_semi)
                    begin
                        event_kind       = EV_SEMI;
                        equals_seen_next = 1'b0;
                    end
                    else if (byte_class.is_equals)
                    begin
                        if (equals_seen_reg)
                        begin
                            event_kind      = EV_ERROR;
                            phase_next      = PH_ERROR;
                            err_code_next   = ERR_TWO_EQUALS;
                            err_offset_next = position_reg;
                        end
                        else
                        begin
                            event_kind       = EV_EQUALS;
                            equals_seen_next = 1'b1;
                        end
                    end
                    else if (byte_class.is_rbrace)
                    begin
                        if (type_empty_reg)
                        begin
                            event_kind      = EV_ERROR;
                            phase_next      = PH_ERROR;
                            err_code_next   = ERR_NO_TYPE;
                            err_offset_next = tag_start_reg;
                        end
                        else
                        begin
                            event_kind       = EV_RBRACE;
                            phase_next       = PH_TEXT;
                            equals_seen_next = 1'b0;
                            quoted_next      = 1'b0;
                        end
                    end
                    else if (byte_class.is_body)
                    begin
                        event_kind = EV_BODY;
                    end
                    else
                    begin
                        event_kind      = EV_ERROR;
                        phase_next      = PH_ERROR;
                        err_code_next   = ERR_BODY_CHAR;
                        err_offset_next = position_reg;
                    end
                end
                default:
                begin
                    event_kind = EV_ERROR;
                end
            endcase

            // error events report the latched error
            if (event_kind == EV_ERROR)
            begin
                error_code   = err_code_next;
                event_offset = err_offset_next;
            end
            tag_begin_offset = tag_start_next;
        end
    end

endmodule : mtt_parser
`default_nettype wire

FILE: sv/mtt_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_skid
// two-entry output buffer: result register plus skid register
// ----------------------------------------------------------------------------
module mtt_skid #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    logic             main_valid_reg, main_valid_next;
    logic [WIDTH-1:0] main_data_reg,  main_data_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [WIDTH-1:0] skid_data_reg,  skid_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_comb
    begin
        in_ready        = !skid_valid_reg;
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (out_ready || !main_valid_reg)
        begin
            // result register free: refill from skid first, else from input
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = in_valid;
                main_data_next  = in_data;
            end
        end
        else if (in_valid && !skid_valid_reg)
        begin
            // result held: park the new beat
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule : mtt_skid
`default_nettype wire

FILE: sv/markup_tag_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// markup_tag_tokenizer
// byte-stream tokenizer for %type{key=value;...} markup tags
// ----------------------------------------------------------------------------
// Each input beat carries one document byte, or an end-of-text mark, and
// produces exactly one event beat with its document offset and the offset
// of the '%' that opened the current tag. The block takes one byte per
// cycle while input ready is high: the byte is classified and run through
// the tag state machine in the cycle it is accepted, and the event enters
// the output buffer on the same clock edge. A second output entry lets
// one more beat in while a result waits, so input ready only drops once
// two events are queued. Errors stick until end of text; the end beat
// reports the outcome and returns offsets and state to their reset values.
// The offset counter holds at its maximum once it gets there.
// ----------------------------------------------------------------------------
module markup_tag_tokenizer #(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mtt_in_if.sink      text_in,
    mtt_out_if.source   event_out
);
    import mtt_pkg::*;

    // packed event: kind, offset, error code, tag start
    localparam int EVENT_BITS = 4 + OFFSET_BITS + 3 + OFFSET_BITS;

    byte_class_t            byte_class;
    logic                   in_ready;
    logic                   accept;
    event_kind_t            event_kind;
    logic [OFFSET_BITS-1:0] event_offset;
    error_code_t            error_code;
    logic [OFFSET_BITS-1:0] tag_begin_offset;
    logic [EVENT_BITS-1:0]  event_data;
    logic [EVENT_BITS-1:0]  out_data;

    // a beat is accepted whenever the output buffer has a free entry
    assign accept        = text_in.valid && in_ready;
    assign text_in.ready = in_ready;

    // byte classes: letters, body characters and the tag punctuation
    mtt_classify u_classify (
        .text_byte  (text_in.text_byte),
        .byte_class (byte_class)
    );

    // tag state machine and offset counter, stepped on every accepted beat
    mtt_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .end_of_text      (text_in.end_of_text),
        .byte_class       (byte_class),
        .event_kind       (event_kind),
        .event_offset     (event_offset),
        .error_code       (error_code),
        .tag_begin_offset (tag_begin_offset)
    );

    assign event_data = {event_kind, event_offset, error_code, tag_begin_offset};

    // result register with skid entry
    mtt_skid #(
        .WIDTH (EVENT_BITS)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (text_in.valid),
        .in_ready  (in_ready),
        .in_data   (event_data),
        .out_valid (event_out.valid),
        .out_ready (event_out.ready),
        .out_data  (out_data)
    );

    // unpack the event onto the output channel
    assign event_out.event_kind       = out_data[EVENT_BITS-1 -: 4];
    assign event_out.event_offset     = out_data[EVENT_BITS-5 -: OFFSET_BITS];
    assign event_out.error_code       = out_data[OFFSET_BITS+2 -: 3];
    assign event_out.tag_begin_offset = out_data[OFFSET_BITS-1:0];

endmodule : markup_tag_tokenizer
`default_nettype wire
